// ===== src/basr_pkg.sv =====
// Shared types and constants for the box-average stereo resampler.
// No dependencies; used by basr_div, box_average_stereo_resampler and the bench.
package basr_pkg;

    localparam int unsigned SampleW   = 16;
    localparam int unsigned RateW     = 16;
    localparam int unsigned AccW      = 32;
    localparam int unsigned OutW      = 8;
    // accumulator / 256 gives the dividend of the divide
    localparam int unsigned DvdW      = AccW - 8;
    localparam int unsigned MaxWords  = 6;
    localparam int unsigned WordCntW  = $clog2(MaxWords + 1);

    localparam logic [RateW-1:0]    ResetRate = 16'd44100;
    localparam logic [SampleW-1:0]  SignFlip  = 16'h8000;

    // configuration register indexes
    localparam logic CfgInRate  = 1'b0;
    localparam logic CfgOutRate = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_MUL_L,
        ST_MUL_R,
        ST_ACC_R,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DvdW-1:0]   dividend_l;
        logic [DvdW-1:0]   dividend_r;
        logic [RateW-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [OutW-1:0]   quot_l;
        logic [OutW-1:0]   quot_r;
    } div_rsp_t;

endpackage

// ===== src/basr_div.sv =====
// Two-lane restoring divider, one quotient bit per cycle per lane.
// Depends on basr_pkg; keeps only the low quotient bits.
module basr_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  basr_pkg::div_req_t   req,
    output basr_pkg::div_rsp_t   rsp
);

    localparam int unsigned DvdW  = basr_pkg::DvdW;
    localparam int unsigned RateW = basr_pkg::RateW;
    localparam int unsigned OutW  = basr_pkg::OutW;
    localparam int unsigned CntW  = $clog2(DvdW + 1);

    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DvdW-1:0]  dvd_l_reg, dvd_l_next, dvd_r_reg, dvd_r_next;
    logic [RateW-1:0] rem_l_reg, rem_l_next, rem_r_reg, rem_r_next;
    logic [RateW-1:0] dsr_reg, dsr_next;
    logic [OutW-1:0]  q_l_reg, q_l_next, q_r_reg, q_r_next;
    logic [RateW:0]   trial_l, trial_r;

    always_comb begin
        trial_l = {rem_l_reg, dvd_l_reg[DvdW-1]} - {1'b0, dsr_reg};
        trial_r = {rem_r_reg, dvd_r_reg[DvdW-1]} - {1'b0, dsr_reg};
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        dvd_l_next = dvd_l_reg;
        dvd_r_next = dvd_r_reg;
        rem_l_next = rem_l_reg;
        rem_r_next = rem_r_reg;
        dsr_next   = dsr_reg;
        q_l_next   = q_l_reg;
        q_r_next   = q_r_reg;
        if (req.start) begin
            cnt_next   = CntW'(DvdW);
            dvd_l_next = req.dividend_l;
            dvd_r_next = req.dividend_r;
            dsr_next   = req.divisor;
            rem_l_next = '0;
            rem_r_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == CntW'(1));
            dvd_l_next = {dvd_l_reg[DvdW-2:0], 1'b0};
            dvd_r_next = {dvd_r_reg[DvdW-2:0], 1'b0};
            // trial sign bit clear: divisor fits
            if (!trial_l[RateW]) begin
                rem_l_next = trial_l[RateW-1:0];
            end else begin
                rem_l_next = {rem_l_reg[RateW-2:0], dvd_l_reg[DvdW-1]};
            end
            if (!trial_r[RateW]) begin
                rem_r_next = trial_r[RateW-1:0];
            end else begin
                rem_r_next = {rem_r_reg[RateW-2:0], dvd_r_reg[DvdW-1]};
            end
            q_l_next = {q_l_reg[OutW-2:0], ~trial_l[RateW]};
            q_r_next = {q_r_reg[OutW-2:0], ~trial_r[RateW]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dvd_l_reg <= dvd_l_next;
        dvd_r_reg <= dvd_r_next;
        rem_l_reg <= rem_l_next;
        rem_r_reg <= rem_r_next;
        dsr_reg   <= dsr_next;
        q_l_reg   <= q_l_next;
        q_r_reg   <= q_r_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.quot_l = q_l_reg;
    assign rsp.quot_r = q_r_reg;

endmodule

// ===== src/box_average_stereo_resampler.sv =====
// Top level of the box-average stereo resampler: sequencer, shared multiply-
// accumulate datapath and output register. Depends on basr_pkg and basr_div.
//
// Usage:
//   Slave stream s_*: one signed 16-bit stereo sample per word.
//   Master stream m_*: unsigned 8-bit stereo samples (128 = silence); m_tlast
//   marks the final output word caused by one input word (up to six).
//   Config port: cfg_we/cfg_addr/cfg_wdata; index 0 = in_rate, 1 = out_rate.
//   Write only while idle. Writing in_rate restarts the output period phase.
// Sequence:
//   One input word at a time; s_tready is high only in the idle state.
//   A word that closes no output period goes through accept, compare, two
//   multiplies on the one 16x16 multiplier, accumulate and compare. Each
//   output period it closes adds compare, the two multiplies, accumulate
//   and the bit-serial divide by 256*in_rate (start, 24 quotient bits,
//   done), run on both channels in parallel, then the output state.
// Reset (aresetn, synchronous, low): both rates go to 44100, the period
//   restarts, accumulators clear and the output register empties.
// Stall: the output word waits in a register; the sequencer holds in its
//   output state until that register frees up, then continues the item.
module box_average_stereo_resampler (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] left_sample, [31:16] right_sample
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: [7:0] left_out, [15:8] right_out; m_tlast = last_of_run
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int unsigned SampleW  = basr_pkg::SampleW;
    localparam int unsigned RateW    = basr_pkg::RateW;
    localparam int unsigned AccW     = basr_pkg::AccW;
    localparam int unsigned OutW     = basr_pkg::OutW;
    localparam int unsigned WordCntW = basr_pkg::WordCntW;

    basr_pkg::state_t state_reg, state_next;

    logic [RateW-1:0]    in_rate_reg, in_rate_next;
    logic [RateW-1:0]    out_rate_reg, out_rate_next;
    logic [RateW-1:0]    eff_in, cfg_eff_in;
    logic [SampleW-1:0]  lv_reg, lv_next, rv_reg, rv_next;
    logic [RateW-1:0]    left_reg, left_next;      // units of this word still to place
    logic [RateW-1:0]    pr_reg, pr_next;          // units left in the output period
    logic [RateW-1:0]    units_reg, units_next;
    logic                emit_reg, emit_next;
    logic                last_reg, last_next;
    logic [WordCntW-1:0] wcnt_reg, wcnt_next;
    logic [AccW-1:0]     prod_reg, prod_next;
    logic [AccW-1:0]     acc_l_reg, acc_l_next, acc_r_reg, acc_r_next;
    logic [SampleW-1:0]  mul_a;
    logic [AccW-1:0]     mul_p;
    logic [RateW:0]      diff;

    logic                mv_reg, mv_next;
    logic [2*OutW-1:0]   md_reg, md_next;
    logic                ml_reg, ml_next;

    basr_pkg::div_req_t  div_req;
    basr_pkg::div_rsp_t  div_rsp;

    basr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // zero in_rate behaves as a one-unit period
    assign eff_in     = (in_rate_reg == '0) ? RateW'(1) : in_rate_reg;
    assign cfg_eff_in = (cfg_wdata == '0) ? RateW'(1) : cfg_wdata;

    // the shared multiplier
    assign mul_p = AccW'(mul_a) * AccW'(units_reg);

    assign diff = {1'b0, left_reg} - {1'b0, pr_reg};

    assign div_req.start      = (state_reg == basr_pkg::ST_DIV_GO);
    assign div_req.dividend_l = acc_l_reg[AccW-1:8];
    assign div_req.dividend_r = acc_r_reg[AccW-1:8];
    assign div_req.divisor    = eff_in;

    always_comb begin
        state_next    = state_reg;
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        lv_next       = lv_reg;
        rv_next       = rv_reg;
        left_next     = left_reg;
        pr_next       = pr_reg;
        units_next    = units_reg;
        emit_next     = emit_reg;
        last_next     = last_reg;
        wcnt_next     = wcnt_reg;
        prod_next     = prod_reg;
        acc_l_next    = acc_l_reg;
        acc_r_next    = acc_r_reg;
        mv_next       = mv_reg;
        md_next       = md_reg;
        ml_next       = ml_reg;
        mul_a         = lv_reg;
        s_tready      = 1'b0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            basr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (cfg_we) begin
                    if (cfg_addr == basr_pkg::CfgInRate) begin
                        in_rate_next = cfg_wdata;
                        pr_next      = cfg_eff_in;
                        acc_l_next   = '0;
                        acc_r_next   = '0;
                    end else begin
                        out_rate_next = cfg_wdata;
                    end
                end
                if (s_tvalid) begin
                    // sign flip = offset binary (sample + 32768)
                    lv_next   = s_tdata[SampleW-1:0] ^ basr_pkg::SignFlip;
                    rv_next   = s_tdata[2*SampleW-1:SampleW] ^ basr_pkg::SignFlip;
                    left_next = out_rate_reg;
                    wcnt_next = '0;
                    if (out_rate_reg != '0) begin
                        state_next = basr_pkg::ST_CMP;
                    end
                end
            end
            basr_pkg::ST_CMP: begin
                if (left_reg == '0) begin
                    state_next = basr_pkg::ST_IDLE;
                end else begin
                    emit_next  = !diff[RateW];
                    units_next = diff[RateW] ? left_reg : pr_reg;
                    // last word if nothing crosses after this boundary
                    last_next  = (diff[RateW:0] == '0) || diff[RateW]
                                 || (wcnt_reg == WordCntW'(basr_pkg::MaxWords - 1))
                                 || (diff[RateW-1:0] < eff_in);
                    state_next = basr_pkg::ST_MUL_L;
                end
            end
            basr_pkg::ST_MUL_L: begin
                mul_a      = lv_reg;
                prod_next  = mul_p;
                state_next = basr_pkg::ST_MUL_R;
            end
            basr_pkg::ST_MUL_R: begin
                mul_a      = rv_reg;
                acc_l_next = acc_l_reg + prod_reg;
                prod_next  = mul_p;
                state_next = basr_pkg::ST_ACC_R;
            end
            basr_pkg::ST_ACC_R: begin
                acc_r_next = acc_r_reg + prod_reg;
                if (emit_reg) begin
                    left_next  = diff[RateW-1:0];
                    state_next = basr_pkg::ST_DIV_GO;
                end else begin
                    pr_next    = pr_reg - left_reg;
                    left_next  = '0;
                    state_next = basr_pkg::ST_CMP;
                end
            end
            basr_pkg::ST_DIV_GO: begin
                state_next = basr_pkg::ST_DIV_WAIT;
            end
            basr_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = basr_pkg::ST_OUT;
                end
            end
            basr_pkg::ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {div_rsp.quot_r, div_rsp.quot_l};
                    ml_next    = last_reg;
                    acc_l_next = '0;
                    acc_r_next = '0;
                    pr_next    = eff_in;
                    wcnt_next  = wcnt_reg + 1'b1;
                    if (wcnt_reg == WordCntW'(basr_pkg::MaxWords - 1)) begin
                        // past the sixth word the rest of the item is dropped
                        left_next  = '0;
                        state_next = basr_pkg::ST_IDLE;
                    end else begin
                        // any remainder opens the next period
                        state_next = basr_pkg::ST_CMP;
                    end
                end
            end
            default: begin
                state_next = basr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= basr_pkg::ST_IDLE;
            in_rate_reg  <= basr_pkg::ResetRate;
            out_rate_reg <= basr_pkg::ResetRate;
            pr_reg       <= basr_pkg::ResetRate;
            acc_l_reg    <= '0;
            acc_r_reg    <= '0;
            left_reg     <= '0;
            wcnt_reg     <= '0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_rate_reg  <= in_rate_next;
            out_rate_reg <= out_rate_next;
            pr_reg       <= pr_next;
            acc_l_reg    <= acc_l_next;
            acc_r_reg    <= acc_r_next;
            left_reg     <= left_next;
            wcnt_reg     <= wcnt_next;
            mv_reg       <= mv_next;
        end
        lv_reg    <= lv_next;
        rv_reg    <= rv_next;
        units_reg <= units_next;
        emit_reg  <= emit_next;
        last_reg  <= last_next;
        prod_reg  <= prod_next;
        md_reg    <= md_next;
        ml_reg    <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule

// ===== src/basr_check.sv =====
// Port-level checker for box_average_stereo_resampler, bound to the top.
// Depends only on the top level's ports.
module basr_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a new output word is only loaded while an item is in progress
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output word loaded while idle");

    // from idle no output word can appear in the next cycle
    a_idle_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |=> !$rose(m_tvalid))
        else $error("output word right after idle");

endmodule

bind box_average_stereo_resampler basr_check u_basr_check (.*);

// ===== bench/box_average_stereo_resampler_tb.sv =====
// Self-checking bench for box_average_stereo_resampler: directed table, then random rate phases.
// Expected output words come from a behavioral area-averaging predictor kept in this file.
// Depends on basr_pkg (rate reset, sign flip, register indexes, word limit) and the RTL.
`timescale 1ns / 1ps

module box_average_stereo_resampler_tb;

    localparam int unsigned CycleLimit  = 600000;
    // wait this long after the last word; longer than the worst item takes
    localparam int unsigned DrainCycles = 200;
    localparam int unsigned RandomItems = 370;
    localparam int unsigned NumExt      = 8;

    // extreme rate settings walked before the random ones (in_rate, out_rate)
    localparam logic [15:0] ExtIn  [NumExt] = '{16'd8000, 16'd48000, 16'd65535, 16'd1,
                                              16'd0, 16'd65535, 16'd44100, 16'd3};
    localparam logic [15:0] ExtOut [NumExt] = '{16'd48000, 16'd8000, 16'd65535, 16'd65535,
                                              16'd7, 16'd0, 16'd48000, 16'd20};

    typedef struct packed {
        logic [7:0] left_out;
        logic [7:0] right_out;
        logic       last_of_run;
    } pcm8_word_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // ROW_CFG: addr/a = register and value. ROW_ITEM: a/b = left/right sample;
    // typed rows give n words of (el, er) instead of the predicted ones.
    typedef struct {
        row_kind_t   kind;
        logic        addr;
        logic [15:0] a;
        logic [15:0] b;
        bit          typed;
        int unsigned n;
        logic [7:0]  el;
        logic [7:0]  er;
    } dir_row_t;

    localparam int unsigned NumDir = 28;

    dir_row_t dir_table [NumDir] = '{
        // after reset both rates are equal: one word per sample, value = offset >> 8
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h8000, 16'h7fff, 1'b1, 1, 8'd0,   8'd255},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h7fff, 16'h8000, 1'b1, 1, 8'd255, 8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h0000, 16'h0000, 1'b1, 1, 8'd128, 8'd128},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'hffff, 16'h00ff, 1'b1, 1, 8'd127, 8'd128},
        // zero out_rate: sample lasts no time, nothing comes out
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd0,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h1234, 16'hedcb, 1'b1, 0, 8'd0,   8'd0},
        // zero in_rate acts as a one-unit period
        '{ROW_CFG,  basr_pkg::CfgInRate,  16'd0,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd3,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h7fff, 16'h8000, 1'b1, 3, 8'd255, 8'd0},
        // more boundaries than the word limit: capped at six
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd10,   16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h0000, 16'hffff, 1'b1, 6, 8'd128, 8'd127},
        // top register values
        '{ROW_CFG,  basr_pkg::CfgInRate,  16'd65535, 16'd0,   1'b0, 0, 8'd0,   8'd0},
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd65535, 16'd0,   1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h8000, 16'h7fff, 1'b1, 1, 8'd0,   8'd255},
        // long period, short samples; then out_rate changes with the phase kept
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd1,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h4000, 16'hc000, 1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h7fff, 16'h0001, 1'b0, 0, 8'd0,   8'd0},
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd65535, 16'd0,   1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h0100, 16'hff00, 1'b0, 0, 8'd0,   8'd0},
        '{ROW_CFG,  basr_pkg::CfgInRate,  16'd1,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd65535, 16'd0,   1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h5555, 16'haaaa, 1'b1, 6, 8'd213, 8'd42},
        // fractional overlap, then an in_rate write mid-period restarts the phase
        '{ROW_CFG,  basr_pkg::CfgInRate,  16'd3,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_CFG,  basr_pkg::CfgOutRate, 16'd2,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h1111, 16'h2222, 1'b0, 0, 8'd0,   8'd0},
        '{ROW_CFG,  basr_pkg::CfgInRate,  16'd5,    16'd0,    1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'hf000, 16'h0fff, 1'b0, 0, 8'd0,   8'd0},
        '{ROW_ITEM, basr_pkg::CfgInRate,  16'h9abc, 16'h6543, 1'b0, 0, 8'd0,   8'd0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // [15:0] left_sample, [31:16] right_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [7:0] left_out, [15:8] right_out
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    box_average_stereo_resampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------
    // Predictor state: rates, units left in the open output period,
    // per-channel weighted sums.
    // ---------------------------------------------------------------
    logic [15:0] rate_in;
    logic [15:0] rate_out;
    logic [31:0] period_left;
    logic [31:0] sum_left;
    logic [31:0] sum_right;

    pcm8_word_t  expected_pcm8 [$];   // words still owed by the block
    pcm8_word_t  step_pcm8 [$];       // words one sample produces

    bit          idle_on;
    int unsigned mismatch_count;
    int unsigned words_checked;
    int unsigned samples_sent;
    int unsigned rate_writes;
    int unsigned cycle_count;

    function automatic logic [31:0] period_units();
        return (rate_in == 16'd0) ? 32'd1 : {16'd0, rate_in};
    endfunction

    function automatic void restart_period();
        period_left = period_units();
        sum_left    = '0;
        sum_right   = '0;
    endfunction

    // close the open period: average = sum / (256 * in_rate), truncated
    function automatic void close_period();
        logic [63:0] divisor;
        logic [63:0] quot_l;
        logic [63:0] quot_r;
        pcm8_word_t  w;
        divisor       = 64'd256 * period_units();
        quot_l        = {32'd0, sum_left} / divisor;
        quot_r        = {32'd0, sum_right} / divisor;
        w.left_out    = quot_l[7:0];
        w.right_out   = quot_r[7:0];
        w.last_of_run = 1'b0;
        step_pcm8.push_back(w);
        restart_period();
    endfunction

    function automatic void resample_step(input logic [15:0] l, input logic [15:0] r);
        logic [31:0] lv;
        logic [31:0] rv;
        logic [31:0] span;
        logic [31:0] part;
        int unsigned n;
        lv   = {16'd0, l ^ basr_pkg::SignFlip};
        rv   = {16'd0, r ^ basr_pkg::SignFlip};
        span = {16'd0, rate_out};
        n    = 0;
        step_pcm8.delete();
        while (span != 0 && n < basr_pkg::MaxWords) begin
            part      = (span < period_left) ? span : period_left;
            sum_left  = sum_left + lv * part;
            sum_right = sum_right + rv * part;
            span      = span - part;
            if (part == period_left) begin
                close_period();
                n++;
            end else begin
                period_left = period_left - part;
            end
        end
        // what is left after the sixth word is dropped
        if (n > 0)
            step_pcm8[n-1].last_of_run = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Clock and cycle limit
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d words owed", cycle_count,
                     expected_pcm8.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Output side: random back-pressure per word
    // ---------------------------------------------------------------
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Check every accepted output word against the oldest expectation.
    always @(posedge aclk) begin
        pcm8_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pcm8.size() == 0) begin
                $error("output word with nothing expected: tdata %h tlast %b",
                       m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = expected_pcm8.pop_front();
                words_checked++;
                if (m_tdata[7:0] !== want.left_out) begin
                    $error("left_out: expected %0d, got %0d", want.left_out, m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tdata[15:8] !== want.right_out) begin
                    $error("right_out: expected %0d, got %0d", want.right_out, m_tdata[15:8]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Hold off input until every owed word is out, then let the block settle.
    task automatic settle_output();
        s_tvalid <= 1'b0;
        while (expected_pcm8.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // Register writes only land while the block is idle.
    task automatic write_rate(input logic addr, input logic [15:0] value);
        settle_output();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (addr == basr_pkg::CfgInRate) begin
            rate_in = value;
            restart_period();
        end else begin
            rate_out = value;
        end
        rate_writes++;
    endtask

    // Send one stereo word; on acceptance queue either the predicted words
    // or, for typed rows, n copies of (el, er) with tlast on the final one.
    task automatic send_sample(input logic [15:0] l, input logic [15:0] r, input bit typed,
                               input int unsigned n, input logic [7:0] el,
                               input logic [7:0] er);
        int unsigned gap;
        pcm8_word_t  w;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        resample_step(l, r);
        if (typed) begin
            for (int unsigned k = 0; k < n; k++) begin
                w.left_out    = el;
                w.right_out   = er;
                w.last_of_run = (k == n - 1);
                expected_pcm8.push_back(w);
            end
        end else begin
            foreach (step_pcm8[k]) expected_pcm8.push_back(step_pcm8[k]);
        end
    endtask

    // full-scale and zero samples show up often, the rest is uniform
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_rate();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 65535));
            1, 2:    return 16'($urandom_range(8000, 48000));
            3:       return 16'($urandom_range(0, 8));
            4:       return 16'($urandom_range(1, 60));     // small: word cap likely
            default: return 16'd65535;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        dir_row_t    row;
        int unsigned ph;
        int unsigned n_items;
        int unsigned random_sent;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_addr    = basr_pkg::CfgInRate;
        cfg_wdata   = '0;
        idle_on     = 1'b1;
        random_sent = 0;

        rate_in  = basr_pkg::ResetRate;
        rate_out = basr_pkg::ResetRate;
        restart_period();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.kind == ROW_CFG)
                write_rate(row.addr, row.a);
            else
                send_sample(row.a, row.b, row.typed, row.n, row.el, row.er);
        end

        // Random phases: extremes first, then random rate pairs. Now and
        // then only out_rate changes so the open period carries over.
        for (ph = 0; random_sent < RandomItems; ph++) begin
            if (ph < NumExt) begin
                write_rate(basr_pkg::CfgInRate, ExtIn[ph]);
                write_rate(basr_pkg::CfgOutRate, ExtOut[ph]);
            end else if ($urandom_range(0, 3) == 0) begin
                write_rate(basr_pkg::CfgOutRate, rand_rate());
            end else begin
                write_rate(basr_pkg::CfgInRate, rand_rate());
                write_rate(basr_pkg::CfgOutRate, rand_rate());
            end
            idle_on = ($urandom_range(0, 3) != 0);
            n_items = $urandom_range(10, 30);
            repeat (n_items) begin
                send_sample(rand_sample(), rand_sample(), 1'b0, 0, 8'd0, 8'd0);
                random_sent++;
                // occasionally wait for the output to run dry mid-phase
                if ($urandom_range(0, 40) == 0)
                    settle_output();
            end
        end

        settle_output();

        $display("Covered %0d stereo samples over %0d rate phases and %0d register writes;",
                 samples_sent, ph, rate_writes);
        $display("%0d output words compared, %0d mismatches.", words_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/basr_pkg.sv
src/basr_div.sv
src/box_average_stereo_resampler.sv
src/basr_check.sv
bench/box_average_stereo_resampler_tb.sv
